@@ sv/rlb_pkg.sv @@
`timescale 1ns / 1ps
// Package for the reciprocal lattice box pipeline: widths, rule codes,
// lane masks and the product index tables. No dependencies.
package rlb_pkg;

	// Lane and operand widths.
	localparam int LANES     = 10;
	localparam int NPROD     = 18;
	localparam int NCROSS    = 9;
	localparam int A_W       = 32;
	localparam int P_W       = 2 * A_W;
	localparam int C_W       = P_W + 1;
	localparam int V_W       = C_W + A_W;
	localparam int NUM_W     = 128;
	localparam int DIV_STEPS = 32;
	localparam int DEN_SH    = 28;
	localparam int CMP_W     = V_W + DEN_SH + DIV_STEPS;

	// Two pi with 60 fraction bits.
	localparam logic [62:0] TWO_PI_Q60 = 63'h6487ED5110B4611A;

	// Saturation bounds of the Q16.16 result.
	localparam logic [A_W-1:0] SAT_POS = 32'h7FFFFFFF;
	localparam logic [A_W-1:0] SAT_NEG = 32'h80000000;

	// Rule codes carried by the dimension field.
	localparam logic [2:0] DIM_1D   = 3'd1;
	localparam logic [2:0] DIM_2D   = 3'd2;
	localparam logic [2:0] DIM_3D   = 3'd3;
	localparam logic [2:0] DIM_DIAG = 3'd4;

	// Lanes that each rule produces (lane index equals the box entry index).
	localparam logic [LANES-1:0] MASK_1D   = 10'b00_0000_0001;
	localparam logic [LANES-1:0] MASK_2D   = 10'b00_0001_1011;
	localparam logic [LANES-1:0] MASK_3D   = 10'b01_1111_1111;
	localparam logic [LANES-1:0] MASK_DIAG = 10'b11_0001_0001;

	// Cross product terms: cross[j] = a[PA[2j]]*a[PB[2j]] - a[PA[2j+1]]*a[PB[2j+1]].
	localparam int PROD_A [NPROD] = '{4, 5, 5, 3, 3, 4,
	                                  7, 8, 8, 6, 6, 7,
	                                  1, 2, 2, 0, 0, 1};
	localparam int PROD_B [NPROD] = '{8, 7, 6, 8, 7, 6,
	                                  2, 1, 0, 2, 1, 0,
	                                  5, 4, 3, 5, 4, 3};

endpackage

@@ sv/reciprocal_lattice_box.sv @@
`timescale 1ns / 1ps
// Reciprocal lattice box: a 40-stage pipeline that turns one box into its
// 2*pi scaled dual box per cycle when not stalled. Depends on rlb_pkg.
//
//  channel | dir | handshake         | payload
//  s_      | in  | s_tvalid/s_tready | s_tuser dimension, s_tdata box entries
//  m_      | out | m_tvalid/m_tready | m_tuser singular, m_tdata dual box entries
//
// One item enters per cycle while the output register is empty or taken.
// Most of the depth is the restoring divider, one quotient bit per stage
// in each of ten parallel lanes, after six product and sum stages.
// All stages advance together whenever the output register is empty or taken.
// Reset clears only the valid bits; the datapath holds during a stall.
module reciprocal_lattice_box
	import rlb_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// box_00, box_01, box_02, box_10, box_11, box_12, box_20, box_21, box_22, box_33
	input  logic [LANES*A_W-1:0] s_tdata,
	// dimension
	input  logic [2:0]           s_tuser,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// recip_00, recip_01, recip_02, recip_10, recip_11, recip_12, recip_20,
	// recip_21, recip_22, recip_33
	output logic [LANES*A_W-1:0] m_tdata,
	// singular
	output logic                 m_tuser
);

	// Quotient bits resolved per item, one per divider stage.
	localparam int Q_W = DIV_STEPS;

	logic adv;

	// Stage registers.
	logic                    vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;
	logic [2:0]              dim_s1, dim_s2, dim_s3, dim_s4, dim_s5;
	logic signed [A_W-1:0]   a_s1 [LANES];
	logic signed [A_W-1:0]   a_s2 [LANES];
	logic signed [A_W-1:0]   a_s3 [LANES];
	logic signed [A_W-1:0]   a_s4 [LANES];
	logic signed [A_W-1:0]   a_s5 [LANES];
	logic signed [P_W-1:0]   prod_s2 [NPROD];
	logic signed [C_W-1:0]   c_s3 [LANES];
	logic signed [C_W-1:0]   c8_s4, c8_s5;
	logic [P_W-1:0]          nmag_s4 [LANES];
	logic [LANES-1:0]        nneg_s4, nneg_s5, act_s4, act_s5;
	logic signed [C_W-1:0]   vhi_s4 [3];
	logic signed [C_W-1:0]   vlo_s4 [3];
	logic signed [V_W-1:0]   vol_s5;
	logic [P_W-1:0]          np_s5 [LANES][4];
	logic [NUM_W-1:0]        num_s6 [LANES];
	logic [V_W-1:0]          dmag_s6 [LANES];
	logic [LANES-1:0]        neg_s6, act_s6;
	logic                    sing_s6;
	logic [2:0]              dim_s6;

	// Divider stage registers; index 0 holds the overflow check.
	logic                    dv_vld_s  [DIV_STEPS+1];
	logic                    dv_sing_s [DIV_STEPS+1];
	logic [2:0]              dv_dim_s  [DIV_STEPS+1];
	logic [NUM_W-1:0]        dv_rem_s  [DIV_STEPS+1][LANES];
	logic [V_W-1:0]          dv_den_s  [DIV_STEPS+1][LANES];
	logic [Q_W-1:0]          dv_q_s    [DIV_STEPS+1][LANES];
	logic [LANES-1:0]        dv_neg_s  [DIV_STEPS+1];
	logic [LANES-1:0]        dv_ovf_s  [DIV_STEPS+1];
	logic [LANES-1:0]        dv_act_s  [DIV_STEPS+1];

	logic                    out_vld_s40, out_user_s40;
	logic [2:0]              out_dim_s40;
	logic [LANES*A_W-1:0]    out_data_s40;

	// Combinational helpers.
	logic signed [C_W-1:0]   n_c [LANES];
	logic [LANES-1:0]        act_c;
	logic signed [V_W-1:0]   d_c [LANES];
	logic                    sing_c;
	logic                    ge_c   [DIV_STEPS+1][LANES];
	logic [NUM_W-1:0]        diff_c [DIV_STEPS+1][LANES];
	logic [A_W-1:0]          res_c  [LANES];

	// The whole pipeline moves when the output register can take an item.
	assign adv      = !out_vld_s40 || m_tready;
	assign s_tready = adv;
	assign m_tvalid = out_vld_s40;
	assign m_tdata  = out_data_s40;
	assign m_tuser  = out_user_s40;

	// Valid bits travel with the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1      <= 1'b0;
			vld_s2      <= 1'b0;
			vld_s3      <= 1'b0;
			vld_s4      <= 1'b0;
			vld_s5      <= 1'b0;
			vld_s6      <= 1'b0;
			out_vld_s40 <= 1'b0;
			for (int k = 0; k <= DIV_STEPS; k++) begin
				dv_vld_s[k] <= 1'b0;
			end
		end else if (adv) begin
			vld_s1      <= s_tvalid;
			vld_s2      <= vld_s1;
			vld_s3      <= vld_s2;
			vld_s4      <= vld_s3;
			vld_s5      <= vld_s4;
			vld_s6      <= vld_s5;
			dv_vld_s[0] <= vld_s6;
			for (int k = 1; k <= DIV_STEPS; k++) begin
				dv_vld_s[k] <= dv_vld_s[k-1];
			end
			out_vld_s40 <= dv_vld_s[DIV_STEPS];
		end
	end

	// Stages 1 to 3: capture, pairwise products, cross product components.
	always_ff @(posedge clk) begin
		if (adv) begin
			dim_s1 <= s_tuser;
			for (int l = 0; l < LANES; l++) begin
				a_s1[l] <= s_tdata[l*A_W +: A_W];
			end
			for (int p = 0; p < NPROD; p++) begin
				prod_s2[p] <= a_s1[PROD_A[p]] * a_s1[PROD_B[p]];
			end
			dim_s2 <= dim_s1;
			a_s2   <= a_s1;
			for (int j = 0; j < NCROSS; j++) begin
				c_s3[j] <= C_W'(prod_s2[2*j]) - C_W'(prod_s2[2*j+1]);
			end
			c_s3[LANES-1] <= '0;
			dim_s3 <= dim_s2;
			a_s3   <= a_s2;
		end
	end

	// Per-lane numerator chosen by the rule.
	always_comb begin
		case (dim_s3)
			DIM_1D:   act_c = MASK_1D;
			DIM_2D:   act_c = MASK_2D;
			DIM_3D:   act_c = MASK_3D;
			DIM_DIAG: act_c = MASK_DIAG;
			default:  act_c = '0;
		endcase
		for (int l = 0; l < LANES; l++) begin
			n_c[l] = '0;
			case (dim_s3)
				DIM_1D, DIM_DIAG: begin
					n_c[l] = C_W'(1);
				end
				DIM_2D: begin
					case (l)
						0:       n_c[l] = C_W'(a_s3[4]);
						1:       n_c[l] = -C_W'(a_s3[1]);
						3:       n_c[l] = -C_W'(a_s3[3]);
						4:       n_c[l] = C_W'(a_s3[0]);
						default: n_c[l] = '0;
					endcase
				end
				DIM_3D: begin
					n_c[l] = c_s3[l];
				end
				default: begin
					n_c[l] = '0;
				end
			endcase
		end
	end

	// Stage 4: numerator magnitudes and split partial products of the volume.
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int l = 0; l < LANES; l++) begin
				nneg_s4[l] <= n_c[l][C_W-1];
				nmag_s4[l] <= n_c[l][C_W-1] ? P_W'(-n_c[l]) : P_W'(n_c[l]);
			end
			for (int i = 0; i < 3; i++) begin
				vhi_s4[i] <= a_s3[i] * $signed(c_s3[i][C_W-1:A_W]);
				vlo_s4[i] <= a_s3[i] * $signed({1'b0, c_s3[i][A_W-1:0]});
			end
			act_s4 <= act_c;
			c8_s4  <= c_s3[NCROSS-1];
			dim_s4 <= dim_s3;
			a_s4   <= a_s3;
		end
	end

	// Stage 5: volume sum and numerator partial products with 2*pi.
	always_ff @(posedge clk) begin
		if (adv) begin
			vol_s5 <= (V_W'(vhi_s4[0]) <<< A_W) + V_W'(vlo_s4[0])
			        + (V_W'(vhi_s4[1]) <<< A_W) + V_W'(vlo_s4[1])
			        + (V_W'(vhi_s4[2]) <<< A_W) + V_W'(vlo_s4[2]);
			for (int l = 0; l < LANES; l++) begin
				np_s5[l][0] <= nmag_s4[l][A_W-1:0]   * TWO_PI_Q60[31:0];
				np_s5[l][1] <= nmag_s4[l][A_W-1:0]   * TWO_PI_Q60[62:32];
				np_s5[l][2] <= nmag_s4[l][P_W-1:A_W] * TWO_PI_Q60[31:0];
				np_s5[l][3] <= nmag_s4[l][P_W-1:A_W] * TWO_PI_Q60[62:32];
			end
			nneg_s5 <= nneg_s4;
			act_s5  <= act_s4;
			c8_s5   <= c8_s4;
			dim_s5  <= dim_s4;
			a_s5    <= a_s4;
		end
	end

	// Per-lane divisor and the singular check.
	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			case (dim_s5)
				DIM_1D, DIM_DIAG: d_c[l] = V_W'(a_s5[l]);
				DIM_2D:           d_c[l] = V_W'(c8_s5);
				DIM_3D:           d_c[l] = vol_s5;
				default:          d_c[l] = '0;
			endcase
		end
		case (dim_s5)
			DIM_1D:   sing_c = (a_s5[0] == '0);
			DIM_2D:   sing_c = (c8_s5 == '0);
			DIM_3D:   sing_c = (vol_s5 == '0);
			DIM_DIAG: sing_c = (a_s5[0] == '0) || (a_s5[4] == '0)
			                || (a_s5[8] == '0) || (a_s5[9] == '0);
			default:  sing_c = 1'b0;
		endcase
	end

	// Stage 6: full numerator, divisor magnitude and result sign.
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int l = 0; l < LANES; l++) begin
				num_s6[l]  <= (NUM_W'(np_s5[l][3]) << (2*A_W))
				            + ((NUM_W'(np_s5[l][1]) + NUM_W'(np_s5[l][2])) << A_W)
				            + NUM_W'(np_s5[l][0]);
				dmag_s6[l] <= d_c[l][V_W-1] ? V_W'(-d_c[l]) : V_W'(d_c[l]);
				neg_s6[l]  <= nneg_s5[l] ^ d_c[l][V_W-1];
			end
			act_s6  <= act_s5;
			sing_s6 <= sing_c;
			dim_s6  <= dim_s5;
		end
	end

	// Divider compare and subtract, one quotient bit per stage.
	always_comb begin
		for (int k = 1; k <= DIV_STEPS; k++) begin
			for (int l = 0; l < LANES; l++) begin
				ge_c[k][l] = CMP_W'(dv_rem_s[k-1][l])
				          >= (CMP_W'(dv_den_s[k-1][l]) << (DEN_SH + DIV_STEPS - k));
				diff_c[k][l] = NUM_W'(CMP_W'(dv_rem_s[k-1][l])
				          - (CMP_W'(dv_den_s[k-1][l]) << (DEN_SH + DIV_STEPS - k)));
			end
		end
		for (int l = 0; l < LANES; l++) begin
			ge_c[0][l]   = 1'b0;
			diff_c[0][l] = '0;
		end
	end

	// Stages 7 to 39: overflow check, then the restoring divider.
	always_ff @(posedge clk) begin
		if (adv) begin
			dv_sing_s[0] <= sing_s6;
			dv_dim_s[0]  <= dim_s6;
			dv_neg_s[0]  <= neg_s6;
			dv_act_s[0]  <= act_s6;
			for (int l = 0; l < LANES; l++) begin
				dv_rem_s[0][l]    <= num_s6[l];
				dv_den_s[0][l]    <= dmag_s6[l];
				dv_q_s[0][l]      <= '0;
				dv_ovf_s[0][l]    <= CMP_W'(num_s6[l])
				                  >= (CMP_W'(dmag_s6[l]) << (DEN_SH + DIV_STEPS));
			end
			for (int k = 1; k <= DIV_STEPS; k++) begin
				dv_sing_s[k] <= dv_sing_s[k-1];
				dv_dim_s[k]  <= dv_dim_s[k-1];
				dv_neg_s[k]  <= dv_neg_s[k-1];
				dv_ovf_s[k]  <= dv_ovf_s[k-1];
				dv_act_s[k]  <= dv_act_s[k-1];
				for (int l = 0; l < LANES; l++) begin
					dv_den_s[k][l] <= dv_den_s[k-1][l];
					dv_rem_s[k][l] <= ge_c[k][l] ? diff_c[k][l] : dv_rem_s[k-1][l];
					dv_q_s[k][l]   <= {dv_q_s[k-1][l][Q_W-2:0], ge_c[k][l]};
				end
			end
		end
	end

	// Sign, saturation and masking of each lane.
	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			if (dv_sing_s[DIV_STEPS] || !dv_act_s[DIV_STEPS][l]) begin
				res_c[l] = '0;
			end else if (dv_neg_s[DIV_STEPS][l]) begin
				if (dv_ovf_s[DIV_STEPS][l] || (A_W'(dv_q_s[DIV_STEPS][l]) > SAT_NEG)) begin
					res_c[l] = SAT_NEG;
				end else begin
					res_c[l] = -A_W'(dv_q_s[DIV_STEPS][l]);
				end
			end else begin
				if (dv_ovf_s[DIV_STEPS][l] || (A_W'(dv_q_s[DIV_STEPS][l]) > SAT_POS)) begin
					res_c[l] = SAT_POS;
				end else begin
					res_c[l] = A_W'(dv_q_s[DIV_STEPS][l]);
				end
			end
		end
	end

	// Stage 40: output register.
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int l = 0; l < LANES; l++) begin
				out_data_s40[l*A_W +: A_W] <= res_c[l];
			end
			out_user_s40 <= dv_sing_s[DIV_STEPS];
			out_dim_s40  <= dv_dim_s[DIV_STEPS];
		end
	end

	// A singular box leaves every entry at zero.
	a_sing_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata == '0)
		else $error("singular item with nonzero entries");

	// Only a defined rule can find a zero divisor.
	a_sing_dim: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> out_dim_s40 == DIM_1D || out_dim_s40 == DIM_2D
			|| out_dim_s40 == DIM_3D || out_dim_s40 == DIM_DIAG)
		else $error("singular flag on an unused dimension");

	// The 1D rule fills only the first entry.
	a_dim1_lanes: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && out_dim_s40 == DIM_1D |-> m_tdata[LANES*A_W-1:A_W] == '0)
		else $error("1D item with entries beyond recip_00");

	// The 2D rule leaves the third row, third column and entry 33 at zero.
	a_dim2_lanes: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && out_dim_s40 == DIM_2D |->
			m_tdata[3*A_W-1:2*A_W] == '0 && m_tdata[LANES*A_W-1:5*A_W] == '0)
		else $error("2D item with entries outside the upper-left block");

endmodule

@@ verif/rlb_checker.sv @@
`timescale 1ns / 1ps
// Checker for the reciprocal lattice box: watches both stream channels,
// predicts each dual box and compares it against the block. Depends on rlb_pkg.
module rlb_checker
	import rlb_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	input  logic                 s_tready,
	input  logic [LANES*A_W-1:0] s_tdata,
	input  logic [2:0]           s_tuser,
	input  logic                 m_tvalid,
	input  logic                 m_tready,
	input  logic [LANES*A_W-1:0] m_tdata,
	input  logic                 m_tuser,
	output int                   errors,
	output int                   pending
);

	typedef struct packed {
		logic [LANES*A_W-1:0] recip;
		logic                 singular;
	} dual_box_t;

	dual_box_t dual_box_q[$];

	// 2*pi (Q60) * n / (d * 2^28), truncated toward zero, saturated to Q16.16.
	function automatic logic [A_W-1:0] scaled_quot(logic [127:0] n, logic [127:0] d);
		logic [127:0] num;
		logic [127:0] den;
		logic [127:0] q;
		logic         neg;
		num = {65'b0, TWO_PI_Q60} * n;
		den = d << DEN_SH;
		neg = num[127] ^ den[127];
		if (num[127]) num = -num;
		if (den[127]) den = -den;
		if (den == 0) return '0;
		q = num / den;
		if (neg) begin
			if (q > 128'h80000000) return SAT_NEG;
			return -q[A_W-1:0];
		end
		if (q > 128'h7FFFFFFF) return SAT_POS;
		return q[A_W-1:0];
	endfunction

	function automatic logic [127:0] cross_term(logic [127:0] p, logic [127:0] q,
			logic [127:0] r, logic [127:0] s);
		return p * q - r * s;
	endfunction

	function automatic dual_box_t predict_dual_box(logic [2:0] dim,
			logic [LANES*A_W-1:0] data);
		logic [127:0] a[LANES];
		logic [127:0] c[NCROSS];
		logic [127:0] det;
		logic [A_W-1:0] res[LANES];
		logic         sing;
		dual_box_t    o;
		sing = 1'b0;
		for (int i = 0; i < LANES; i++) begin
			a[i] = {{96{data[i*A_W+A_W-1]}}, data[i*A_W +: A_W]};
			res[i] = '0;
		end
		case (dim)
			DIM_1D: begin
				if (a[0] == 0) sing = 1'b1;
				else res[0] = scaled_quot(128'd1, a[0]);
			end
			DIM_2D: begin
				det = a[0] * a[4] - a[1] * a[3];
				if (det == 0) sing = 1'b1;
				else begin
					res[0] = scaled_quot(a[4], det);
					res[1] = scaled_quot(-a[1], det);
					res[3] = scaled_quot(-a[3], det);
					res[4] = scaled_quot(a[0], det);
				end
			end
			DIM_3D: begin
				// Row i of the dual box is the cross product of the other two rows.
				for (int r = 0; r < 3; r++) begin
					int u;
					int v;
					u = 3 * ((r + 1) % 3);
					v = 3 * ((r + 2) % 3);
					c[3*r]   = cross_term(a[u+1], a[v+2], a[u+2], a[v+1]);
					c[3*r+1] = cross_term(a[u+2], a[v], a[u], a[v+2]);
					c[3*r+2] = cross_term(a[u], a[v+1], a[u+1], a[v]);
				end
				det = a[0] * c[0] + a[1] * c[1] + a[2] * c[2];
				if (det == 0) sing = 1'b1;
				else for (int j = 0; j < NCROSS; j++) res[j] = scaled_quot(c[j], det);
			end
			DIM_DIAG: begin
				if (a[0] == 0 || a[4] == 0 || a[8] == 0 || a[9] == 0) sing = 1'b1;
				else begin
					res[0] = scaled_quot(128'd1, a[0]);
					res[4] = scaled_quot(128'd1, a[4]);
					res[8] = scaled_quot(128'd1, a[8]);
					res[9] = scaled_quot(128'd1, a[9]);
				end
			end
			default: ;
		endcase
		for (int i = 0; i < LANES; i++) o.recip[i*A_W +: A_W] = sing ? '0 : res[i];
		o.singular = sing;
		return o;
	endfunction

	assign pending = dual_box_q.size();

	// Predict on input acceptance, compare on output acceptance.
	always @(posedge clk or negedge arst_n) begin
		dual_box_t exp_box;
		logic      bad;
		if (!arst_n) begin
			errors <= 0;
		end else begin
			if (s_tvalid && s_tready) dual_box_q.push_back(predict_dual_box(s_tuser, s_tdata));
			if (m_tvalid && m_tready) begin
				if (dual_box_q.size() == 0) begin
					if (errors < 10) $display("unexpected dual box at %0t", $realtime);
					errors <= errors + 1;
				end else begin
					exp_box = dual_box_q.pop_front();
					bad = (exp_box.singular !== m_tuser);
					for (int i = 0; i < LANES; i++)
						if (exp_box.recip[i*A_W +: A_W] !== m_tdata[i*A_W +: A_W]) bad = 1'b1;
					if (bad) begin
						if (errors < 10) begin
							$display("mismatch at %0t: singular exp %0b got %0b",
								$realtime, exp_box.singular, m_tuser);
							for (int i = 0; i < LANES; i++)
								$display("  lane %0d exp %h got %h", i,
									exp_box.recip[i*A_W +: A_W], m_tdata[i*A_W +: A_W]);
						end
						errors <= errors + 1;
					end
				end
			end
		end
	end

endmodule

@@ verif/tb_reciprocal_lattice_box.sv @@
`timescale 1ns / 1ps
// Testbench top for the reciprocal lattice box: drives boxes with random
// gaps and stalls and gives the verdict. Depends on rlb_pkg and rlb_checker.
module tb_reciprocal_lattice_box;
	import rlb_pkg::*;

	localparam int WATCHDOG = 20000;

	logic                 clk;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [LANES*A_W-1:0] s_tdata;
	logic [2:0]           s_tuser;
	logic                 m_tvalid;
	logic                 m_tready;
	logic [LANES*A_W-1:0] m_tdata;
	logic                 m_tuser;
	int                   errors;
	int                   pending;
	int                   idle_cycles = 0;

	reciprocal_lattice_box dut (.*);

	rlb_checker u_checker (.*);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	// Gap length: mostly none or short, now and then long.
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// Box entry: full range, small values, or an extreme.
	function automatic logic [A_W-1:0] rand_entry();
		int r;
		r = $urandom_range(0, 9);
		if (r < 3) return $urandom;
		if (r < 8) return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
		case ($urandom_range(0, 4))
			0: return 32'h0000_0000;
			1: return 32'h0000_0001;
			2: return 32'hFFFF_FFFF;
			3: return SAT_POS;
			default: return SAT_NEG;
		endcase
	endfunction

	task automatic send_box(logic [2:0] dim, logic [LANES*A_W-1:0] data);
		int g;
		g = gap_len();
		if (g > 0) begin
			s_tvalid <= 1'b0;
			repeat (g) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= dim;
		s_tdata  <= data;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	task automatic send_random_box();
		logic [LANES*A_W-1:0] d;
		logic [2:0]           dim;
		int                   k;
		for (int i = 0; i < LANES; i++) d[i*A_W +: A_W] = rand_entry();
		k = $urandom_range(0, 99);
		if (k < 4) dim = 3'($urandom_range(0, 7));
		else dim = 3'($urandom_range(1, 4));
		// Now and then force a singular box for the 2D, 3D and diagonal rules.
		if ($urandom_range(0, 19) == 0) begin
			d[3*A_W +: A_W] = d[0 +: A_W];
			d[4*A_W +: A_W] = d[A_W +: A_W];
			d[5*A_W +: A_W] = d[2*A_W +: A_W];
			if (dim == DIM_DIAG) d[9*A_W +: A_W] = '0;
		end
		send_box(dim, d);
	endtask

	// Receiver stalls: stretches of always-ready and stretches of random stalls.
	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if ($urandom_range(0, 3) == 0) begin
				m_tready <= 1'b1;
				repeat ($urandom_range(20, 80)) @(negedge clk);
			end else begin
				m_tready <= 1'b0;
				repeat (gap_len()) @(negedge clk);
				m_tready <= 1'b1;
			end
		end
	end

	// Watchdog on cycles without any accepted item.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		logic [LANES*A_W-1:0] d;
		s_tvalid = 1'b0;
		s_tuser  = '0;
		s_tdata  = '0;
		arst_n   = 1'b0;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: identity-like boxes, extremes, singular cases, unused codes.
		d = '0;
		d[0 +: A_W] = 32'h0001_0000;
		d[4*A_W +: A_W] = 32'h0001_0000;
		d[8*A_W +: A_W] = 32'h0001_0000;
		d[9*A_W +: A_W] = 32'h0001_0000;
		for (int k = 0; k < 8; k++) send_box(3'(k), d);
		send_box(DIM_1D, '0);
		send_box(DIM_1D, {LANES{32'h0000_0001}});
		send_box(DIM_1D, {LANES{SAT_NEG}});
		send_box(DIM_1D, {LANES{SAT_POS}});
		send_box(DIM_1D, {LANES{32'hFFFF_FFFF}});
		send_box(DIM_2D, {LANES{32'h0002_0000}});
		send_box(DIM_3D, {LANES{32'h0002_0000}});
		send_box(DIM_DIAG, {32'h0, {9{32'h0003_0000}}});
		send_box(DIM_2D, {LANES{32'h5555_AAAA}});
		send_box(DIM_2D, {LANES{32'hAAAA_5555}});
		send_box(DIM_3D, (LANES*A_W)'({8{32'h8000_0001, 32'h7FFF_FFFE}} >> 192));
		send_box(DIM_3D, {LANES{32'hFFFF_FFFF}}
			^ {32'h0, 32'h1, 96'h0, 32'h1, 96'h0, 32'h1});
		send_box(DIM_2D, {LANES{32'h0000_0001}} ^ 320'h1);

		for (int n = 0; n < 1850; n++) send_random_box();
		s_tvalid <= 1'b0;

		while (pending != 0) @(posedge clk);
		repeat (60) @(posedge clk);
		if (errors == 0) $display("TB_OK");
		else $display("TB_ERROR");
		$finish;
	end

endmodule

@@ reciprocal_lattice_box.f @@
sv/rlb_pkg.sv
sv/reciprocal_lattice_box.sv
verif/rlb_checker.sv
verif/tb_reciprocal_lattice_box.sv
